/* hdl/owm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_BIT   = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_BIT   = 2'd2,
        PH_BYTE  = 2'd3
    } op_phase_t;

    // Configuration register indexes
    localparam int unsigned NUM_REGS = 7;
    localparam logic [2:0] REG_RESET_LOW_END   = 3'd0;
    localparam logic [2:0] REG_RESET_SAMPLE_AT = 3'd1;
    localparam logic [2:0] REG_RESET_SLOT_END  = 3'd2;
    localparam logic [2:0] REG_ONE_LOW_END     = 3'd3;
    localparam logic [2:0] REG_ZERO_LOW_END    = 3'd4;
    localparam logic [2:0] REG_BIT_SAMPLE_AT   = 3'd5;
    localparam logic [2:0] REG_BIT_SLOT_END    = 3'd6;

    localparam int unsigned CFG_WIDTH = 16;
    typedef logic [CFG_WIDTH-1:0] cfg_word_t;
    typedef cfg_word_t cfg_array_t [NUM_REGS];

    localparam cfg_array_t CFG_RESET_VALS = '{
        16'd960, 16'd1104, 16'd1920, 16'd17, 16'd160, 16'd48, 16'd320
    };

    localparam int unsigned BITS_PER_BYTE_DEF = 8;
    localparam int unsigned COUNT_WIDTH_DEF   = 16;

endpackage

`default_nettype wire

/* hdl/one_wire_master_timing.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                              Direction  Item
// s         s_tvalid s_tready s_tdata s_tuser    in         one timer tick + command
// m         m_tvalid m_tready m_tdata            out        bus drive and status of that tick
// cfg       cfg_valid cfg_ready cfg_index cfg_data in       timing register write
//
// Each tick item is processed as it is accepted; the slot state and the output register
// both update at the accepting edge, so the result is on m in the next cycle.
// Back-to-back ticks run at one per cycle; s_tready drops only while the output
// register is full and m_tready is low.
// Reset clears the slot state, loads the default timing, and empties the output.
// cfg_ready is always high; timing registers are read live by the compares.

module one_wire_master_timing
    import owm_pkg::*;
#(
    parameter int unsigned BITS_PER_BYTE = BITS_PER_BYTE_DEF,
    parameter int unsigned COUNT_WIDTH   = COUNT_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // send_data[7:0], line_in[8], zero pad
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                        // recv_data[10:3], presence[11],
                                        // echo_match[12], zero pad

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int unsigned CW    = COUNT_WIDTH;
    localparam int unsigned CMP_W = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

    cfg_word_t cfg_reg [NUM_REGS];

    logic [CW-1:0] tick_count_reg, tick_count_next;
    op_phase_t     op_phase_reg, op_phase_next;
    logic [3:0]    bit_index_reg, bit_index_next;
    logic [7:0]    tx_shift_reg, tx_shift_next;
    logic [7:0]    rx_shift_reg, rx_shift_next;
    logic [7:0]    sent_copy_reg, sent_copy_next;
    logic          line_sample_reg, line_sample_next;
    logic          line_low_reg, line_low_next;

    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg;

    logic          in_accept;
    logic [1:0]    cmd;
    logic [7:0]    send_data;
    logic          line_in;

    logic          busy, done, pres, echo;
    logic [7:0]    recv;
    logic [CMP_W-1:0] tick_ext, low_end, sample_at, slot_end;
    logic [3:0]    bit_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign cmd       = s_tuser;
    assign send_data = s_tdata[7:0];
    assign line_in   = s_tdata[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET_VALS[i];
            end
        end
        else if (cfg_valid && cfg_ready && (32'(cfg_index) < NUM_REGS))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // One tick of slot timing
    always_comb
    begin
        op_phase_next    = op_phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        sent_copy_next   = sent_copy_reg;
        line_sample_next = line_sample_reg;
        line_low_next    = line_low_reg;
        busy = 1'b0;
        done = 1'b0;
        pres = 1'b0;
        echo = 1'b0;
        recv = 8'd0;

        if (op_phase_reg == PH_IDLE && cmd != CMD_NONE)
        begin
            op_phase_next    = op_phase_t'(cmd);
            bit_index_next   = 4'd0;
            tx_shift_next    = send_data;
            sent_copy_next   = send_data;
            rx_shift_next    = 8'd0;
            tick_count_next  = '0;
            line_sample_next = 1'b1;
        end

        bit_inc = bit_index_next + 4'd1;

        tick_ext = CMP_W'(tick_count_next);
        if (op_phase_next == PH_RESET)
        begin
            low_end   = CMP_W'(cfg_reg[REG_RESET_LOW_END]);
            sample_at = CMP_W'(cfg_reg[REG_RESET_SAMPLE_AT]);
            slot_end  = CMP_W'(cfg_reg[REG_RESET_SLOT_END]);
        end
        else
        begin
            low_end   = tx_shift_next[0] ? CMP_W'(cfg_reg[REG_ONE_LOW_END])
                                         : CMP_W'(cfg_reg[REG_ZERO_LOW_END]);
            sample_at = CMP_W'(cfg_reg[REG_BIT_SAMPLE_AT]);
            slot_end  = CMP_W'(cfg_reg[REG_BIT_SLOT_END]);
        end

        if (op_phase_next != PH_IDLE)
        begin
            if (tick_ext == CMP_W'(1))
            begin
                line_low_next = 1'b1;
            end
            if (tick_ext == low_end)
            begin
                line_low_next = 1'b0;
            end
            if (tick_ext == sample_at)
            begin
                line_sample_next = line_in;
            end

            if (tick_ext == slot_end)
            begin
                line_low_next = 1'b0;
                case (op_phase_next)
                    PH_RESET:
                    begin
                        done = 1'b1;
                        pres = !line_sample_next;
                        op_phase_next = PH_IDLE;
                    end
                    PH_BIT:
                    begin
                        done = 1'b1;
                        recv = {7'd0, line_sample_next};
                        op_phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        rx_shift_next  = {line_sample_next, rx_shift_next[7:1]};
                        tx_shift_next  = {1'b0, tx_shift_next[7:1]};
                        bit_index_next = bit_inc;
                        if (32'(bit_inc) >= BITS_PER_BYTE)
                        begin
                            done = 1'b1;
                            recv = rx_shift_next;
                            echo = (rx_shift_next == sent_copy_next);
                            op_phase_next = PH_IDLE;
                        end
                        else
                        begin
                            tick_count_next  = '0;
                            line_sample_next = 1'b1;
                            busy = 1'b1;
                        end
                    end
                endcase
                if (op_phase_next == PH_IDLE)
                begin
                    tick_count_next = '0;
                end
            end
            else
            begin
                if (tick_count_next != {CW{1'b1}})
                begin
                    tick_count_next = tick_count_next + CW'(1);
                end
                busy = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_phase_reg    <= PH_IDLE;
            tick_count_reg  <= '0;
            bit_index_reg   <= 4'd0;
            tx_shift_reg    <= 8'd0;
            rx_shift_reg    <= 8'd0;
            sent_copy_reg   <= 8'd0;
            line_sample_reg <= 1'b1;
            line_low_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                op_phase_reg    <= op_phase_next;
                tick_count_reg  <= tick_count_next;
                bit_index_reg   <= bit_index_next;
                tx_shift_reg    <= tx_shift_next;
                rx_shift_reg    <= rx_shift_next;
                sent_copy_reg   <= sent_copy_next;
                line_sample_reg <= line_sample_next;
                line_low_reg    <= line_low_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            m_tdata_reg <= {3'd0, echo, pres, recv, done, busy, line_low_next};
        end
    end

`ifndef ASSERT_OFF
    // An idle master has its counter parked and the wire released
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        op_phase_reg == PH_IDLE |-> (tick_count_reg == '0) && !line_low_reg)
        else $error("idle with running counter or wire held low");

    // The finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("done and busy in the same tick");

    // Presence and echo only accompany a finish
    a_flags_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11] || m_tdata[12]) |-> m_tdata[2])
        else $error("status flag without done");

    // Every accepted tick produces a result in the next cycle
    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_tvalid)
        else $error("accepted tick produced no result");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import owm_pkg::*;

    localparam int STALL_LIMIT = 1000;

    // Result fields in m_tdata order, lowest bit last
    typedef struct packed {
        logic       echo_match;
        logic       presence;
        logic [7:0] recv_data;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } tick_out_t;

    typedef enum logic [1:0] {
        LINE_LOW  = 2'd0,
        LINE_HIGH = 2'd1,
        LINE_ECHO = 2'd2,
        LINE_RAND = 2'd3
    } line_mode_t;

    // Slot timing predictor plus the queue of per-tick outputs it expects
    class tick_scoreboard;
        cfg_word_t   timing [NUM_REGS];
        op_phase_t   phase;
        logic [15:0] tick_cnt;
        logic [3:0]  bit_idx;
        logic [7:0]  tx_bits;
        logic [7:0]  rx_bits;
        logic [7:0]  sent_byte;
        logic        sampled;
        logic        wire_low;
        tick_out_t   expected_q [$];
        int          errors;
        int          ticks;

        function new();
            timing    = CFG_RESET_VALS;
            phase     = PH_IDLE;
            tick_cnt  = '0;
            bit_idx   = '0;
            tx_bits   = '0;
            rx_bits   = '0;
            sent_byte = '0;
            sampled   = 1'b1;
            wire_low  = 1'b0;
            errors    = 0;
            ticks     = 0;
        endfunction

        function void write_timing(logic [2:0] idx, logic [15:0] val);
            if (idx < NUM_REGS)
                timing[idx] = val;
        endfunction

        function void note_tick(logic [1:0] cmd, logic [7:0] data, logic line);
            tick_out_t   r;
            logic [15:0] low_end;
            logic [15:0] sample_at;
            logic [15:0] slot_end;
            r = '0;
            ticks++;
            if (phase == PH_IDLE && cmd != CMD_NONE) begin
                phase     = op_phase_t'(cmd);
                bit_idx   = '0;
                tx_bits   = data;
                sent_byte = data;
                rx_bits   = '0;
                tick_cnt  = '0;
                sampled   = 1'b1;
            end
            if (phase != PH_IDLE) begin
                if (phase == PH_RESET) begin
                    low_end   = timing[REG_RESET_LOW_END];
                    sample_at = timing[REG_RESET_SAMPLE_AT];
                    slot_end  = timing[REG_RESET_SLOT_END];
                end
                else begin
                    low_end   = tx_bits[0] ? timing[REG_ONE_LOW_END] : timing[REG_ZERO_LOW_END];
                    sample_at = timing[REG_BIT_SAMPLE_AT];
                    slot_end  = timing[REG_BIT_SLOT_END];
                end
                if (tick_cnt == 16'd1)
                    wire_low = 1'b1;
                if (tick_cnt == low_end)
                    wire_low = 1'b0;
                if (tick_cnt == sample_at)
                    sampled = line;
                if (tick_cnt == slot_end) begin
                    wire_low = 1'b0;
                    case (phase)
                        PH_RESET:
                        begin
                            r.done_res = 1'b1;
                            r.presence = !sampled;
                            phase      = PH_IDLE;
                        end
                        PH_BIT:
                        begin
                            r.done_res  = 1'b1;
                            r.recv_data = {7'd0, sampled};
                            phase       = PH_IDLE;
                        end
                        default:
                        begin
                            // LSB first out, received bits enter at the top
                            rx_bits = {sampled, rx_bits[7:1]};
                            tx_bits = tx_bits >> 1;
                            bit_idx = bit_idx + 4'd1;
                            if (int'(bit_idx) >= BITS_PER_BYTE_DEF) begin
                                r.done_res   = 1'b1;
                                r.recv_data  = rx_bits;
                                r.echo_match = (rx_bits == sent_byte);
                                phase        = PH_IDLE;
                            end
                            else begin
                                tick_cnt   = '0;
                                sampled    = 1'b1;
                                r.busy_res = 1'b1;
                            end
                        end
                    endcase
                    if (phase == PH_IDLE)
                        tick_cnt = '0;
                end
                else begin
                    if (tick_cnt != 16'hFFFF)
                        tick_cnt = tick_cnt + 16'd1;
                    r.busy_res = 1'b1;
                end
            end
            r.drive_low = wire_low;
            expected_q.push_back(r);
        endfunction

        function void cmp_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(tick_out_t act);
            tick_out_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, act);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            cmp_field("drive_low",  exp_r.drive_low,  act.drive_low);
            cmp_field("busy_res",   exp_r.busy_res,   act.busy_res);
            cmp_field("done_res",   exp_r.done_res,   act.done_res);
            cmp_field("recv_data",  exp_r.recv_data,  act.recv_data);
            cmp_field("presence",   exp_r.presence,   act.presence);
            cmp_field("echo_match", exp_r.echo_match, act.echo_match);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    tick_scoreboard sb;
    cfg_array_t     next_timing;
    logic [31:0]    cycle_cnt;
    int             stall_cnt;
    logic           calm;

    one_wire_master_timing u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // one stretch in four with no idling on either side
    assign calm = (cycle_cnt[10:9] == 2'b11);

    initial begin
        cycle_cnt = '0;
        stall_cnt = 0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 32'd1;
        if (rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_result(tick_out_t'(m_tdata[12:0]));
            if (s_tvalid && s_tready)
                sb.note_tick(s_tuser, s_tdata[7:0], s_tdata[8]);
            if (cfg_valid && cfg_ready)
                sb.write_timing(cfg_index, cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        wait (stall_cnt >= STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    function automatic logic pick_line(line_mode_t mode, logic [1:0] cmd, logic [7:0] data);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            // a device that answers with the bit being sent
            LINE_ECHO:
            begin
                if (sb.phase == PH_IDLE && cmd != CMD_NONE)
                    return data[0];
                return sb.tx_bits[0];
            end
            default:   return 1'($urandom_range(1));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_tick(logic [1:0] cmd, logic [7:0] data, logic line);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, line, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_op(logic [1:0] cmd, logic [7:0] data, line_mode_t mode);
        logic [1:0] noise;
        send_tick(cmd, data, pick_line(mode, cmd, data));
        // commands sent while busy must be ignored
        while (sb.phase != PH_IDLE) begin
            noise = 2'($urandom_range(3));
            send_tick(noise, 8'($urandom_range(255)), pick_line(mode, noise, 8'h00));
        end
        send_tick(CMD_NONE, 8'($urandom_range(255)), pick_line(mode, CMD_NONE, 8'h00));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // writes next_timing once the block has drained
    task automatic load_timing();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
        write_reg(REG_RESET_LOW_END,   next_timing[REG_RESET_LOW_END]);
        write_reg(REG_RESET_SAMPLE_AT, next_timing[REG_RESET_SAMPLE_AT]);
        write_reg(REG_RESET_SLOT_END,  next_timing[REG_RESET_SLOT_END]);
        write_reg(REG_ONE_LOW_END,     next_timing[REG_ONE_LOW_END]);
        write_reg(REG_ZERO_LOW_END,    next_timing[REG_ZERO_LOW_END]);
        write_reg(REG_BIT_SAMPLE_AT,   next_timing[REG_BIT_SAMPLE_AT]);
        write_reg(REG_BIT_SLOT_END,    next_timing[REG_BIT_SLOT_END]);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_random_timing();
        if ($urandom_range(3) == 0) begin
            foreach (next_timing[i])
                next_timing[i] = 16'($urandom_range(12));
        end
        else begin
            // ordered like a real bus: low <= sample < end for reset; both low ends and sample < end for bits
            next_timing[REG_RESET_LOW_END]   = 16'($urandom_range(1, 4));
            next_timing[REG_RESET_SAMPLE_AT] = next_timing[REG_RESET_LOW_END]
                                               + 16'($urandom_range(3));
            next_timing[REG_RESET_SLOT_END]  = next_timing[REG_RESET_SAMPLE_AT]
                                               + 16'($urandom_range(1, 4));
            next_timing[REG_ONE_LOW_END]     = 16'($urandom_range(1, 3));
            next_timing[REG_ZERO_LOW_END]    = next_timing[REG_ONE_LOW_END]
                                               + 16'($urandom_range(1, 4));
            next_timing[REG_BIT_SAMPLE_AT]   = next_timing[REG_ONE_LOW_END]
                                               + 16'($urandom_range(3));
            next_timing[REG_BIT_SLOT_END]    = next_timing[REG_ZERO_LOW_END]
                                               + next_timing[REG_BIT_SAMPLE_AT]
                                               + 16'($urandom_range(3));
        end
    endtask

    initial begin
        int         start_ticks;
        line_mode_t mode;
        logic [1:0] cmd;

        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_NONE;
        cfg_valid = 1'b0;
        cfg_index = REG_RESET_LOW_END;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // power-on timing
        run_op(CMD_BIT,   8'h01, LINE_HIGH);

        next_timing = '{16'd3, 16'd5, 16'd8, 16'd2, 16'd5, 16'd3, 16'd7};
        load_timing();
        run_op(CMD_RESET, 8'h00, LINE_LOW);
        run_op(CMD_RESET, 8'hFF, LINE_HIGH);
        run_op(CMD_BIT,   8'hFE, LINE_LOW);
        run_op(CMD_BIT,   8'h01, LINE_ECHO);
        run_op(CMD_BYTE,  8'h00, LINE_ECHO);
        run_op(CMD_BYTE,  8'hFF, LINE_ECHO);
        run_op(CMD_BYTE,  8'hA5, LINE_RAND);
        run_op(CMD_BYTE,  8'h5A, LINE_LOW);

        // release compare at tick 1 or 0: at 1 the wire is never pulled low, at 0 it stays low until slot end
        next_timing = '{16'd1, 16'd2, 16'd4, 16'd1, 16'd0, 16'd2, 16'd4};
        load_timing();
        run_op(CMD_BIT,   8'h01, LINE_ECHO);
        run_op(CMD_BIT,   8'h00, LINE_ECHO);
        run_op(CMD_RESET, 8'h00, LINE_LOW);
        run_op(CMD_BYTE,  8'h96, LINE_ECHO);

        // sample and release both past slot end
        next_timing = '{16'd9, 16'd9, 16'd3, 16'd9, 16'd9, 16'd9, 16'd3};
        load_timing();
        run_op(CMD_RESET, 8'h00, LINE_LOW);
        run_op(CMD_BYTE,  8'h3C, LINE_LOW);

        // zero-length slots
        next_timing = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        load_timing();
        run_op(CMD_RESET, 8'h00, LINE_LOW);
        run_op(CMD_BIT,   8'h01, LINE_RAND);
        run_op(CMD_BYTE,  8'hC3, LINE_ECHO);

        for (int p = 0; p < 6; p++) begin
            pick_random_timing();
            load_timing();
            start_ticks = sb.ticks;
            while (sb.ticks - start_ticks < 200) begin
                if ($urandom_range(9) == 0) begin
                    send_tick(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                else begin
                    cmd  = 2'($urandom_range(1, 3));
                    mode = ($urandom_range(1) == 0) ? LINE_ECHO
                                                    : line_mode_t'($urandom_range(3));
                    run_op(cmd, 8'($urandom_range(255)), mode);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
